FILE: rtl/pbfc_pkg.sv
`timescale 1ns / 1ps
package pbfc_pkg;
   localparam int COORD_BITS_DEF = 20;
   localparam int NUM_IMAGES = 27;
   localparam int CENTER_IMAGE = 13;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 3 * COORD_BITS_DEF;
   localparam logic [CSR_IDX_BITS-1:0] REG_DOM_LEFT = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_DOM_RIGHT = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_RANK = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_BC_MASK = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_SHEAR_BND = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_SHEAR_VEL = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_SHEAR_OFF = 3'd6;
   localparam logic [1:0] AXIS_NONE = 2'd3;

   // image n: shift of axis d is (n / 3**d) % 3 - 1
   function automatic int image_shift(input int n, input int d);
      int r;
      r = n;
      for (int q = 0; q < d; q++) r = r / 3;
      return (r % 3) - 1;
   endfunction
endpackage

FILE: rtl/pbfc_if.sv
`timescale 1ns / 1ps
interface pbfc_req_if import pbfc_pkg::*; #(parameter int CB = COORD_BITS_DEF) ();
   logic valid;
   logic ready;
   logic [3*CB-1:0] own_left_edges;
   logic [3*CB-1:0] own_right_edges;
   logic [3*CB-1:0] other_left_edges;
   logic [3*CB-1:0] other_right_edges;
   logic [3*CB-1:0] own_cell_widths;
   logic [3*CB-1:0] other_cell_widths;
   logic [3*CB-1:0] own_first_cell_left;
   logic [3*CB-1:0] own_last_cell_left;
   logic same_grid;
   modport source (output valid, own_left_edges, own_right_edges, other_left_edges,
      other_right_edges, own_cell_widths, other_cell_widths, own_first_cell_left,
      own_last_cell_left, same_grid, input ready);
   modport sink (input valid, own_left_edges, own_right_edges, other_left_edges,
      other_right_edges, own_cell_widths, other_cell_widths, own_first_cell_left,
      own_last_cell_left, same_grid, output ready);
endinterface

interface pbfc_rsp_if ();
   logic valid;
   logic ready;
   logic shared_face;
   modport source (output valid, shared_face, input ready);
   modport sink (input valid, shared_face, output ready);
endinterface

FILE: rtl/pbfc_cell.sv
`timescale 1ns / 1ps
// one image test per cell, word handed down the chain each cycle that advance is high
module pbfc_cell import pbfc_pkg::*; #(
   parameter int CB = COORD_BITS_DEF,
   parameter int SX = 0,
   parameter int SY = 0,
   parameter int SZ = 0
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic valid_i,
   input  logic hit_i,
   input  logic [3*CB-1:0] ol_i, or_i, xl_i, xr_i, w_i,
   input  logic [1:0] rank_i,
   input  logic [5:0] chk_i,
   input  logic [5:0] shear_face_i,
   input  logic shear_on_i,
   input  logic [1:0] vel_i,
   input  logic signed [CB+1:0] dw_i [3],
   input  logic [CB-1:0] soff_i,
   output logic valid_o,
   output logic hit_o,
   output logic [3*CB-1:0] ol_o, or_o, xl_o, xr_o, w_o,
   output logic [1:0] rank_o,
   output logic [5:0] chk_o,
   output logic [5:0] shear_face_o,
   output logic shear_on_o,
   output logic [1:0] vel_o,
   output logic signed [CB+1:0] dw_o [3],
   output logic [CB-1:0] soff_o
);
   localparam int WB = CB + 5;
   logic valid_ff, hit_ff;
   logic [3*CB-1:0] ol_ff, or_ff, xl_ff, xr_ff, w_ff;
   logic [1:0] rank_ff, vel_ff;
   logic [5:0] chk_ff, sf_ff;
   logic shon_ff;
   logic signed [CB+1:0] dw_ff [3];
   logic [CB-1:0] soff_ff;
   logic hit_in, allowed, plus_sh, minus_sh, fail;
   logic signed [WB-1:0] off [3];
   logic [1:0] hits;
   int sh [3];

   always_comb begin
      logic signed [WB-1:0] a, c, b, e, lo, hi, wd, df;
      sh[0] = SX; sh[1] = SY; sh[2] = SZ;
      allowed = 1'b1; plus_sh = 1'b0; minus_sh = 1'b0;
      for (int d = 0; d < 3; d++) begin
         if (sh[d] == 1 && !chk_i[2*d]) allowed = 1'b0;
         if (sh[d] == -1 && !chk_i[2*d+1]) allowed = 1'b0;
         if (sh[d] == 1 && shear_face_i[2*d]) plus_sh = 1'b1;
         if (sh[d] == -1 && shear_face_i[2*d+1]) minus_sh = 1'b1;
      end
      if (rank_i < 2'd3 && SZ != 0) allowed = 1'b0;
      if (rank_i < 2'd2 && SY != 0) allowed = 1'b0;
      for (int d = 0; d < 3; d++) begin
         off[d] = (sh[d] == 1) ? WB'(dw_i[d]) : (sh[d] == -1) ? -WB'(dw_i[d]) : '0;
         if (shear_on_i && vel_i == 2'(d)) begin
            if (plus_sh) off[d] = off[d] - WB'({1'b0, soff_i});
            if (minus_sh) off[d] = off[d] + WB'({1'b0, soff_i});
         end
      end
      fail = 1'b0; hits = '0;
      for (int d = 0; d < 3; d++) begin
         a = WB'({1'b0, ol_i[d*CB +: CB]}) + off[d];
         c = WB'({1'b0, or_i[d*CB +: CB]}) + off[d];
         b = WB'({1'b0, xl_i[d*CB +: CB]});
         e = WB'({1'b0, xr_i[d*CB +: CB]});
         wd = WB'({1'b0, w_i[d*CB +: CB]});
         lo = (a > b) ? a : b;
         hi = (c < e) ? c : e;
         df = (lo > hi) ? lo - hi : hi - lo;
         if (2'(d) < rank_i) begin
            if (2*lo - wd >= 2*hi) fail = 1'b1;
            if (2*df < wd) hits = hits + 2'd1;
         end
      end
      hit_in = hit_i | (valid_i & allowed & !fail & (hits == 2'd1));
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (advance) valid_ff <= valid_i;
      if (advance) begin
         hit_ff <= hit_in;
         ol_ff <= ol_i; or_ff <= or_i; xl_ff <= xl_i; xr_ff <= xr_i; w_ff <= w_i;
         rank_ff <= rank_i; chk_ff <= chk_i; sf_ff <= shear_face_i;
         shon_ff <= shear_on_i; vel_ff <= vel_i; dw_ff <= dw_i; soff_ff <= soff_i;
      end
   end
   assign valid_o = valid_ff; assign hit_o = hit_ff;
   assign ol_o = ol_ff; assign or_o = or_ff; assign xl_o = xl_ff; assign xr_o = xr_ff;
   assign w_o = w_ff; assign rank_o = rank_ff; assign chk_o = chk_ff;
   assign shear_face_o = sf_ff; assign shear_on_o = shon_ff; assign vel_o = vel_ff;
   assign dw_o = dw_ff; assign soff_o = soff_ff;
endmodule

FILE: rtl/periodic_box_face_contact.sv
`timescale 1ns / 1ps
// channel | dir | words
// req     | in  | two boxes, widths, first/last cell edges, same_grid
// rsp     | out | shared_face
// csr     | in  | plain register writes
// one word per cycle sustained unless stalled; a taken request passes through
// 27 image cell stages, the last one feeding the output register
// the chain stalls as a whole when the output register is full and not taken
// reset clears valids and registers to their listed values
module periodic_box_face_contact import pbfc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   pbfc_req_if.sink req,
   pbfc_rsp_if.source rsp,
   input  logic csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [3*COORD_BITS-1:0] csr_wdata
);
   localparam int CB = COORD_BITS;
   localparam int N = NUM_IMAGES;
   logic [3*CB-1:0] dl_ff, dr_ff;
   logic [1:0] rank_ff, sb_ff, sv_ff;
   logic [11:0] mask_ff;
   logic [CB-1:0] soff_ff;
   logic advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         dl_ff <= '0; dr_ff <= '1; rank_ff <= 2'd3; mask_ff <= '0;
         sb_ff <= AXIS_NONE; sv_ff <= AXIS_NONE; soff_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_DOM_LEFT: dl_ff <= csr_wdata[3*CB-1:0];
            REG_DOM_RIGHT: dr_ff <= csr_wdata[3*CB-1:0];
            REG_RANK: rank_ff <= csr_wdata[1:0];
            REG_BC_MASK: mask_ff <= csr_wdata[11:0];
            REG_SHEAR_BND: sb_ff <= csr_wdata[1:0];
            REG_SHEAR_VEL: sv_ff <= csr_wdata[1:0];
            REG_SHEAR_OFF: soff_ff <= csr_wdata[CB-1:0];
            default: ;
         endcase
      end
   end

   logic v [N+1]; logic h [N+1];
   logic [3*CB-1:0] ol [N+1], orr [N+1], xl [N+1], xr [N+1], w [N+1];
   logic [1:0] rk [N+1], vl [N+1];
   logic [5:0] ck [N+1], sf [N+1];
   logic so [N+1];
   logic signed [CB+1:0] dw [N+1][3];
   logic [CB-1:0] sof [N+1];

   always_comb begin
      logic [1:0] r;
      r = (rank_ff == 2'd0) ? 2'd1 : rank_ff;
      v[0] = req.valid & req.ready; h[0] = req.same_grid;
      ol[0] = req.own_left_edges; orr[0] = req.own_right_edges;
      xl[0] = req.other_left_edges; xr[0] = req.other_right_edges;
      for (int d = 0; d < 3; d++) begin
         w[0][d*CB +: CB] = (req.own_cell_widths[d*CB +: CB] < req.other_cell_widths[d*CB +: CB])
            ? req.own_cell_widths[d*CB +: CB] : req.other_cell_widths[d*CB +: CB];
         ck[0][2*d] = mask_ff[2*d] && (req.own_first_cell_left[d*CB +: CB] < dl_ff[d*CB +: CB]
            || sv_ff == 2'(d));
         ck[0][2*d+1] = mask_ff[2*d+1] && (req.own_last_cell_left[d*CB +: CB] > dr_ff[d*CB +: CB]
            || sv_ff == 2'(d));
         dw[0][d] = (CB+2)'({1'b0, dr_ff[d*CB +: CB]}) - (CB+2)'({1'b0, dl_ff[d*CB +: CB]});
         if (2'(d) >= r) begin
            ck[0][2*d] = 1'b1; ck[0][2*d+1] = 1'b1; dw[0][d] = '0;
         end
      end
      rk[0] = r; sf[0] = mask_ff[11:6]; so[0] = (sb_ff != AXIS_NONE);
      vl[0] = sv_ff; sof[0] = soff_ff;
   end

   // center image first, it is the direct test
   for (genvar g = 0; g < N; g++) begin : g_cell
      localparam int IDX = (g == 0) ? CENTER_IMAGE : (g <= CENTER_IMAGE ? g - 1 : g);
      pbfc_cell #(.CB(CB), .SX(image_shift(IDX, 0)), .SY(image_shift(IDX, 1)),
         .SZ(image_shift(IDX, 2))) u_cell (
         .clock, .reset, .advance,
         .valid_i(v[g]), .hit_i(h[g]), .ol_i(ol[g]), .or_i(orr[g]), .xl_i(xl[g]),
         .xr_i(xr[g]), .w_i(w[g]), .rank_i(rk[g]), .chk_i(ck[g]), .shear_face_i(sf[g]),
         .shear_on_i(so[g]), .vel_i(vl[g]), .dw_i(dw[g]), .soff_i(sof[g]),
         .valid_o(v[g+1]), .hit_o(h[g+1]), .ol_o(ol[g+1]), .or_o(orr[g+1]), .xl_o(xl[g+1]),
         .xr_o(xr[g+1]), .w_o(w[g+1]), .rank_o(rk[g+1]), .chk_o(ck[g+1]),
         .shear_face_o(sf[g+1]), .shear_on_o(so[g+1]), .vel_o(vl[g+1]), .dw_o(dw[g+1]),
         .soff_o(sof[g+1]));
   end

   logic out_v_ff, out_h_ff;
   assign advance = !out_v_ff || rsp.ready;
   assign req.ready = advance;
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (advance) out_v_ff <= v[N];
      if (advance) out_h_ff <= h[N];
   end
   assign rsp.valid = out_v_ff;
   assign rsp.shared_face = out_h_ff;

`ifndef NO_ASSERTIONS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.shared_face))
      else $error("result dropped under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready) else $error("stalled with empty output");
`endif
endmodule
